### rtl/core/nsc_pkg.sv
`timescale 1ns / 1ps

package nsc_pkg;

    // Field widths.
    localparam int SAMPLE_W = 10;
    localparam int GAIN_W   = 8;
    localparam int TIMER_W  = 8;
    localparam int BAND_W   = 13;
    localparam int FS_SUM_W = 12;
    localparam int STEP_W   = 9;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;

    // Register indexes, taken from paddr[2].
    localparam logic REG_INITIAL_GAIN      = 1'b0;
    localparam logic REG_INITIAL_DIODE_REF = 1'b1;

    // Squelch and calibration constants.
    localparam logic [SAMPLE_W-1:0] CAL_NOISE      = 10'd900;
    localparam logic [SAMPLE_W-1:0] KNOB_MIN       = 10'd26;
    localparam logic [SAMPLE_W-1:0] FULL_SCALE     = 10'd1023;
    localparam logic [SAMPLE_W-1:0] FS_LIMIT       = 10'd1000;
    localparam logic [SAMPLE_W-1:0] FS_THRESH      = 10'd16;
    localparam logic [SAMPLE_W-1:0] AVG_TAPS       = 10'd31;
    localparam logic signed [BAND_W-1:0] HYST      = 13'sd24;
    localparam logic [TIMER_W-1:0]  CLOSE_TICKS    = 8'd70;
    localparam logic [TIMER_W-1:0]  HOLDOFF_TICKS  = 8'd32;
    localparam logic [TIMER_W-1:0]  SETTLE_TICKS   = 8'd100;
    localparam logic [TIMER_W-1:0]  TEST_TICKS     = 8'd128;
    localparam logic [TIMER_W-1:0]  LOW_BLINK      = 8'd200;
    localparam logic [TIMER_W-1:0]  HIGH_BLINK     = 8'd25;
    localparam logic [GAIN_W-1:0]   GAIN_TOP       = 8'd127;
    localparam logic [GAIN_W-1:0]   GAIN_MIN_OK    = 8'd8;

    // Conditioned figures handed from the front end to the controller.
    typedef struct packed {
        logic [SAMPLE_W-1:0] band_lo;
        logic [SAMPLE_W-1:0] band_hi;
        logic [SAMPLE_W-1:0] avg_upd;
        logic [SAMPLE_W-1:0] fs_upd;
    } cond_t;

    // Configuration loads into the live gain and diode reference.
    typedef struct packed {
        logic                gain_we;
        logic [GAIN_W-1:0]   gain;
        logic                dref_we;
        logic [SAMPLE_W-1:0] dref;
    } cfg_write_t;

    // Fast/slow counter step as a function of the recent noise figure.
    function automatic logic signed [STEP_W-1:0] fs_step(input logic [SAMPLE_W-1:0] n);
        logic signed [STEP_W-1:0] s;
        begin
            priority if (n < 10'd16)  s = -9'sd15;
            else if (n < 10'd20)      s = -9'sd13;
            else if (n < 10'd24)      s = -9'sd11;
            else if (n < 10'd30)      s = -9'sd9;
            else if (n < 10'd36)      s = -9'sd7;
            else if (n < 10'd64)      s = -9'sd5;
            else if (n < 10'd72)      s = -9'sd3;
            else if (n < 10'd128)     s = -9'sd1;
            else if (n < 10'd144)     s = 9'sd1;
            else if (n < 10'd256)     s = 9'sd50;
            else if (n < 10'd512)     s = 9'sd100;
            else                      s = 9'sd200;
            return s;
        end
    endfunction

    // Saturate a signed band edge to the ADC range.
    function automatic logic [SAMPLE_W-1:0] clamp_adc(input logic signed [BAND_W-1:0] v);
        logic [SAMPLE_W-1:0] r;
        begin
            priority if (v < 13'sd0)                          r = '0;
            else if (v > signed'({3'b000, FULL_SCALE}))       r = FULL_SCALE;
            else                                              r = v[SAMPLE_W-1:0];
            return r;
        end
    endfunction

endpackage

### rtl/core/nsc_cond.sv
`timescale 1ns / 1ps

module nsc_cond
(
    input  logic [nsc_pkg::SAMPLE_W-1:0] noise,
    input  logic [nsc_pkg::SAMPLE_W-1:0] diode,
    input  logic [nsc_pkg::SAMPLE_W-1:0] knob,
    input  logic [nsc_pkg::SAMPLE_W-1:0] dref,
    input  logic [nsc_pkg::SAMPLE_W-1:0] avg,
    input  logic [nsc_pkg::SAMPLE_W-1:0] prev_noise,
    input  logic [nsc_pkg::SAMPLE_W-1:0] fs_count,
    output nsc_pkg::cond_t               cond
);

    logic [nsc_pkg::SAMPLE_W-1:0]        knob_eff;
    logic signed [nsc_pkg::BAND_W-1:0]   comp;
    logic [14:0]                         avg_sum;
    logic [nsc_pkg::SAMPLE_W:0]          recent_sum;
    logic [nsc_pkg::SAMPLE_W-1:0]        recent;
    logic signed [nsc_pkg::STEP_W-1:0]   step_val;
    logic signed [nsc_pkg::FS_SUM_W-1:0] fs_sum;

    always_comb
    begin
        // Squelch band: knob shifted by diode drift, plus or minus the hysteresis.
        knob_eff = (knob < nsc_pkg::KNOB_MIN) ? nsc_pkg::KNOB_MIN : knob;
        comp = signed'({3'b000, knob_eff}) + signed'({3'b000, dref})
             - signed'({3'b000, diode});
        cond.band_lo = nsc_pkg::clamp_adc(comp - nsc_pkg::HYST);
        cond.band_hi = nsc_pkg::clamp_adc(comp + nsc_pkg::HYST);

        // Running average with a 31/32 weight on the old value.
        avg_sum = {5'b00000, avg} * {5'b00000, nsc_pkg::AVG_TAPS} + {5'b00000, noise};
        cond.avg_upd = avg_sum[14:5];

        // Recent figure is the rounded mean of the two newest samples; it moves
        // the saturating fast/slow counter.
        recent_sum = {1'b0, noise} + {1'b0, prev_noise} + 11'd1;
        recent = recent_sum[nsc_pkg::SAMPLE_W:1];
        step_val = nsc_pkg::fs_step(recent);
        fs_sum = signed'({2'b00, fs_count}) + {{3{step_val[nsc_pkg::STEP_W-1]}}, step_val};
        priority if (fs_sum > signed'({2'b00, nsc_pkg::FS_LIMIT}))
            cond.fs_upd = nsc_pkg::FS_LIMIT;
        else if (fs_sum < 12'sd0)
            cond.fs_upd = '0;
        else
            cond.fs_upd = fs_sum[nsc_pkg::SAMPLE_W-1:0];
    end

endmodule

### rtl/core/nsc_ctrl.sv
`timescale 1ns / 1ps

module nsc_ctrl
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         step,
    input  logic [nsc_pkg::SAMPLE_W-1:0] noise,
    input  logic [nsc_pkg::SAMPLE_W-1:0] diode,
    input  logic [nsc_pkg::SAMPLE_W-1:0] knob,
    input  logic                         calibrate,
    input  logic                         store_diode,
    input  nsc_pkg::cfg_write_t          cfg,
    output logic                         cor,
    output logic                         led,
    output logic [nsc_pkg::GAIN_W-1:0]   gain,
    output logic                         gain_write,
    output logic                         cal_store,
    output logic [nsc_pkg::SAMPLE_W-1:0] diode_ref
);

    typedef enum logic [2:0] {
        SQ_CLOSED    = 3'd0,
        SQ_OPEN      = 3'd1,
        SQ_TAIL      = 3'd2,
        SQ_OPEN_FAST = 3'd3,
        SQ_HOLDOFF   = 3'd4
    } sq_state_t;

    typedef enum logic [2:0] {
        CS_START    = 3'd0,
        CS_DEBOUNCE = 3'd1,
        CS_SET      = 3'd2,
        CS_TEST     = 3'd3,
        CS_DONE     = 3'd4,
        CS_TOO_LOW  = 3'd5,
        CS_TOO_HIGH = 3'd6
    } cal_state_t;

    sq_state_t                     sq_reg, sq_next;
    cal_state_t                    cs_reg, cs_next;
    logic [nsc_pkg::TIMER_W-1:0]   timer_reg, timer_next;
    logic [nsc_pkg::SAMPLE_W-1:0]  avg_reg, avg_next;
    logic [nsc_pkg::SAMPLE_W-1:0]  prev_reg;
    logic [nsc_pkg::SAMPLE_W-1:0]  fs_reg, fs_next;
    logic [nsc_pkg::SAMPLE_W-1:0]  dref_reg, dref_next;
    logic [nsc_pkg::GAIN_W-1:0]    gain_reg, gain_next;
    logic                          cor_reg, cor_next;
    logic                          led_reg, led_next;
    logic                          gain_write_reg, gain_write_next;
    logic                          cal_store_reg, cal_store_next;
    logic [nsc_pkg::GAIN_W-1:0]    gain_inc;
    nsc_pkg::cond_t                cond;

    nsc_cond u_cond
    (
        .noise      (noise),
        .diode      (diode),
        .knob       (knob),
        .dref       (dref_reg),
        .avg        (avg_reg),
        .prev_noise (prev_reg),
        .fs_count   (fs_reg),
        .cond       (cond)
    );

    assign gain_inc = gain_reg + 8'd1;

    // Next state for one tick: calibration sequencer or squelch machine.
    always_comb
    begin
        sq_next         = sq_reg;
        cs_next         = cs_reg;
        timer_next      = (timer_reg != '0) ? timer_reg - 8'd1 : timer_reg;
        avg_next        = cond.avg_upd;
        fs_next         = cond.fs_upd;
        dref_next       = dref_reg;
        gain_next       = gain_reg;
        cor_next        = cor_reg;
        led_next        = led_reg;
        gain_write_next = 1'b0;
        cal_store_next  = 1'b0;

        if (calibrate)
        begin
            cor_next = 1'b0;
            unique case (cs_reg)
                CS_START:
                begin
                    gain_next  = '0;
                    timer_next = nsc_pkg::SETTLE_TICKS;
                    cs_next    = CS_DEBOUNCE;
                end
                CS_DEBOUNCE:
                begin
                    if (timer_next == '0)
                    begin
                        led_next = 1'b0;
                        cs_next  = CS_SET;
                    end
                end
                CS_SET:
                begin
                    avg_next        = '0;
                    gain_write_next = 1'b1;
                    led_next        = (gain_reg[2:0] == 3'b111);
                    timer_next      = nsc_pkg::TEST_TICKS;
                    cs_next         = CS_TEST;
                end
                CS_TEST:
                begin
                    if (timer_next == '0)
                    begin
                        if (avg_next > nsc_pkg::CAL_NOISE)
                        begin
                            if (gain_reg < nsc_pkg::GAIN_MIN_OK)
                            begin
                                cs_next = CS_TOO_HIGH;
                            end
                            else
                            begin
                                if (store_diode)
                                begin
                                    dref_next = diode;
                                end
                                cal_store_next = 1'b1;
                                cs_next        = CS_DONE;
                            end
                        end
                        else
                        begin
                            gain_next = gain_inc;
                            cs_next   = (gain_inc > nsc_pkg::GAIN_TOP) ? CS_TOO_LOW : CS_SET;
                        end
                    end
                end
                CS_DONE:
                begin
                    led_next = 1'b1;
                end
                CS_TOO_LOW:
                begin
                    if (timer_next == '0)
                    begin
                        led_next   = ~led_reg;
                        timer_next = nsc_pkg::LOW_BLINK;
                    end
                end
                CS_TOO_HIGH:
                begin
                    if (timer_next == '0)
                    begin
                        led_next   = ~led_reg;
                        timer_next = nsc_pkg::HIGH_BLINK;
                    end
                end
                default:
                begin
                    cs_next = CS_START;
                end
            endcase
        end
        else
        begin
            cs_next = CS_START;
            unique case (sq_reg)
                SQ_CLOSED:
                begin
                    led_next = 1'b0;
                    cor_next = 1'b0;
                    if (avg_next < cond.band_lo)
                    begin
                        fs_next = nsc_pkg::FS_LIMIT;
                        sq_next = SQ_OPEN;
                    end
                end
                SQ_OPEN:
                begin
                    cor_next = 1'b1;
                    led_next = 1'b1;
                    if (fs_next == '0)
                    begin
                        sq_next = SQ_OPEN_FAST;
                    end
                    else if (avg_next >= cond.band_hi)
                    begin
                        timer_next = nsc_pkg::CLOSE_TICKS;
                        sq_next    = SQ_TAIL;
                    end
                end
                SQ_TAIL:
                begin
                    cor_next = 1'b1;
                    led_next = 1'b1;
                    if (timer_next == '0)
                    begin
                        if (avg_next < cond.band_hi)
                        begin
                            fs_next = nsc_pkg::FS_LIMIT;
                            sq_next = SQ_OPEN;
                        end
                        else
                        begin
                            cor_next = 1'b0;
                            led_next = 1'b0;
                            sq_next  = SQ_CLOSED;
                        end
                    end
                end
                SQ_OPEN_FAST:
                begin
                    cor_next = 1'b1;
                    led_next = 1'b1;
                    if (fs_next > nsc_pkg::FS_THRESH)
                    begin
                        sq_next = SQ_OPEN;
                        fs_next = nsc_pkg::FS_LIMIT;
                    end
                    else if (noise >= cond.band_hi)
                    begin
                        avg_next   = nsc_pkg::CAL_NOISE;
                        timer_next = nsc_pkg::HOLDOFF_TICKS;
                        fs_next    = nsc_pkg::FS_LIMIT;
                        cor_next   = 1'b0;
                        led_next   = 1'b0;
                        sq_next    = SQ_HOLDOFF;
                    end
                end
                SQ_HOLDOFF:
                begin
                    if (timer_next == '0)
                    begin
                        sq_next = SQ_CLOSED;
                    end
                end
                default:
                begin
                    sq_next = SQ_CLOSED;
                end
            endcase
        end
    end

    // State and result registers; configuration loads gain and reference.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_reg         <= SQ_CLOSED;
            cs_reg         <= CS_START;
            timer_reg      <= '0;
            avg_reg        <= nsc_pkg::CAL_NOISE;
            prev_reg       <= '0;
            fs_reg         <= '0;
            dref_reg       <= '0;
            gain_reg       <= '0;
            cor_reg        <= 1'b0;
            led_reg        <= 1'b0;
            gain_write_reg <= 1'b0;
            cal_store_reg  <= 1'b0;
        end
        else if (step)
        begin
            sq_reg         <= sq_next;
            cs_reg         <= cs_next;
            timer_reg      <= timer_next;
            avg_reg        <= avg_next;
            prev_reg       <= noise;
            fs_reg         <= fs_next;
            dref_reg       <= dref_next;
            gain_reg       <= gain_next;
            cor_reg        <= cor_next;
            led_reg        <= led_next;
            gain_write_reg <= gain_write_next;
            cal_store_reg  <= cal_store_next;
        end
        else
        begin
            if (cfg.gain_we)
            begin
                gain_reg <= cfg.gain;
            end
            if (cfg.dref_we)
            begin
                dref_reg <= cfg.dref;
            end
        end
    end

    assign cor        = cor_reg;
    assign led        = led_reg;
    assign gain       = gain_reg;
    assign gain_write = gain_write_reg;
    assign cal_store  = cal_store_reg;
    assign diode_ref  = dref_reg;

    // Carrier is only reported from one of the open squelch states.
    a_cor_open: assert property (@(posedge clk) disable iff (!rst_n)
        cor_reg |-> (sq_reg == SQ_OPEN || sq_reg == SQ_TAIL || sq_reg == SQ_OPEN_FAST))
        else $error("carrier detect outside an open squelch state");

    // A store pulse is only raised on the tick that enters done.
    a_store_done: assert property (@(posedge clk) disable iff (!rst_n)
        cal_store_reg |-> (cs_reg == CS_DONE))
        else $error("calibration store pulse without done state");

    // A gain write comes from the set step, which always moves on to test.
    a_write_test: assert property (@(posedge clk) disable iff (!rst_n)
        gain_write_reg |-> (cs_reg == CS_TEST))
        else $error("gain write pulse outside test state");

    // The fast/slow counter stays inside its saturation range.
    a_fs_range: assert property (@(posedge clk) disable iff (!rst_n)
        fs_reg <= nsc_pkg::FS_LIMIT)
        else $error("fast/slow counter out of range");

endmodule

### rtl/core/noise_squelch_controller.sv
`timescale 1ns / 1ps

// Noise squelch controller. Each input beat carries one sample tick (noise,
// diode and knob samples plus the calibrate and store_diode flags) and
// produces exactly one result beat with carrier detect, the LED, the
// attenuator gain, its write pulse, the calibration store pulse and the
// diode reference. A beat is registered on entry, and the whole tick update
// (band, 31/32 average, fast/slow counter and the squelch or calibration
// machine) is evaluated from the staged beat, once the result slot is free,
// straight into the state and result registers, which present the result
// beat; one beat is taken every cycle as long as results are drained. The APB
// registers initial_gain (address 0) and initial_diode_ref (address 4) load
// the live gain and diode reference when written, unless a tick is evaluated
// in that cycle, and read back their stored values; write them only
// while no beat is in flight.
module noise_squelch_controller
(
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [nsc_pkg::SAMPLE_W-1:0] noise_sample,
    input  logic [nsc_pkg::SAMPLE_W-1:0] diode_sample,
    input  logic [nsc_pkg::SAMPLE_W-1:0] knob_level,
    input  logic                         calibrate,
    input  logic                         store_diode,

    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         carrier_detect,
    output logic                         led,
    output logic [nsc_pkg::GAIN_W-1:0]   gain_value,
    output logic                         gain_write,
    output logic                         cal_store,
    output logic [nsc_pkg::SAMPLE_W-1:0] diode_ref_out,

    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [nsc_pkg::ADDR_W-1:0]   paddr,
    input  logic [nsc_pkg::DATA_W-1:0]   pwdata,
    output logic [nsc_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);

    logic                         in_valid_reg;
    logic [nsc_pkg::SAMPLE_W-1:0] noise_reg;
    logic [nsc_pkg::SAMPLE_W-1:0] diode_reg;
    logic [nsc_pkg::SAMPLE_W-1:0] knob_reg;
    logic                         calibrate_reg;
    logic                         store_diode_reg;
    logic                         out_valid_reg;
    logic                         step;
    logic                         cfg_wr;
    logic [nsc_pkg::GAIN_W-1:0]   initial_gain_reg;
    logic [nsc_pkg::SAMPLE_W-1:0] initial_diode_ref_reg;
    nsc_pkg::cfg_write_t          cfg;

    // The tick is evaluated when a beat is staged and the result slot is free.
    assign step     = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || step;

    // Input staging register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            noise_reg       <= noise_sample;
            diode_reg       <= diode_sample;
            knob_reg        <= knob_level;
            calibrate_reg   <= calibrate;
            store_diode_reg <= store_diode;
        end
    end

    // Result beat valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

    // APB register file.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            initial_gain_reg      <= '0;
            initial_diode_ref_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                nsc_pkg::REG_INITIAL_GAIN:
                begin
                    initial_gain_reg <= pwdata[nsc_pkg::GAIN_W-1:0];
                end
                nsc_pkg::REG_INITIAL_DIODE_REF:
                begin
                    initial_diode_ref_reg <= pwdata[nsc_pkg::SAMPLE_W-1:0];
                end
                default:
                begin
                    initial_gain_reg <= initial_gain_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            nsc_pkg::REG_INITIAL_GAIN:
            begin
                prdata = {{(nsc_pkg::DATA_W-nsc_pkg::GAIN_W){1'b0}}, initial_gain_reg};
            end
            nsc_pkg::REG_INITIAL_DIODE_REF:
            begin
                prdata = {{(nsc_pkg::DATA_W-nsc_pkg::SAMPLE_W){1'b0}}, initial_diode_ref_reg};
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    // A register write also loads the live value, as a load from storage.
    always_comb
    begin
        cfg.gain_we = cfg_wr && (paddr[2] == nsc_pkg::REG_INITIAL_GAIN);
        cfg.gain    = pwdata[nsc_pkg::GAIN_W-1:0];
        cfg.dref_we = cfg_wr && (paddr[2] == nsc_pkg::REG_INITIAL_DIODE_REF);
        cfg.dref    = pwdata[nsc_pkg::SAMPLE_W-1:0];
    end

    nsc_ctrl u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .noise       (noise_reg),
        .diode       (diode_reg),
        .knob        (knob_reg),
        .calibrate   (calibrate_reg),
        .store_diode (store_diode_reg),
        .cfg         (cfg),
        .cor         (carrier_detect),
        .led         (led),
        .gain        (gain_value),
        .gain_write  (gain_write),
        .cal_store   (cal_store),
        .diode_ref   (diode_ref_out)
    );

endmodule

### bench/tb_noise_squelch_controller.sv
`timescale 1ns / 1ps

module tb_noise_squelch_controller;

    typedef logic [nsc_pkg::SAMPLE_W-1:0] sample_t;
    typedef logic [nsc_pkg::GAIN_W-1:0]   gain_t;
    typedef logic [nsc_pkg::DATA_W-1:0]   word_t;
    typedef logic [nsc_pkg::ADDR_W-1:0]   addr_t;

    localparam int HALF_PERIOD = 5;
    localparam addr_t GAIN_ADDR = {nsc_pkg::REG_INITIAL_GAIN, 2'b00};
    localparam addr_t DREF_ADDR = {nsc_pkg::REG_INITIAL_DIODE_REF, 2'b00};

    typedef enum logic [2:0]
    {
        SQ_CLOSED    = 3'd0,
        SQ_OPEN      = 3'd1,
        SQ_TAIL      = 3'd2,
        SQ_OPEN_FAST = 3'd3,
        SQ_HOLDOFF   = 3'd4
    } squelch_t;

    typedef enum logic [2:0]
    {
        CAL_START    = 3'd0,
        CAL_DEBOUNCE = 3'd1,
        CAL_SET      = 3'd2,
        CAL_TEST     = 3'd3,
        CAL_DONE     = 3'd4,
        CAL_TOO_LOW  = 3'd5,
        CAL_TOO_HIGH = 3'd6
    } cal_t;

    // Noise patterns used to steer the squelch through its states.
    typedef enum int
    {
        SEG_QUIET,
        SEG_WEAK,
        SEG_LOUD,
        SEG_SPIKE,
        SEG_MIXED,
        SEG_CAL_BURST
    } segment_t;

    typedef struct packed
    {
        sample_t noise;
        sample_t diode;
        sample_t knob;
        logic    cal;
        logic    store;
    } tick_t;

    typedef struct packed
    {
        logic    cor;
        logic    led;
        gain_t   gain;
        logic    gain_wr;
        logic    store;
        sample_t dref;
    } status_t;

    logic    clk;
    logic    rst_n;
    logic    in_valid;
    logic    in_ready;
    sample_t noise_sample;
    sample_t diode_sample;
    sample_t knob_level;
    logic    calibrate;
    logic    store_diode;
    logic    out_valid;
    logic    out_ready;
    logic    carrier_detect;
    logic    led;
    gain_t   gain_value;
    logic    gain_write;
    logic    cal_store;
    sample_t diode_ref_out;
    logic    psel;
    logic    penable;
    logic    pwrite;
    addr_t   paddr;
    word_t   pwdata;
    word_t   prdata;
    logic    pready;

    bit tx_idle_on  = 1'b1;
    bit rx_stall_on = 1'b1;
    int errors       = 0;
    int ticks_sent   = 0;
    int results_seen = 0;

    // Expected status beats, oldest first.
    status_t status_q[$];

    // Predicted controller state.
    gain_t                              reg_gain;
    sample_t                            reg_dref;
    squelch_t                           sq_state;
    cal_t                               cal_state;
    logic [nsc_pkg::TIMER_W-1:0]        hold_cnt;
    sample_t                            avg_noise;
    sample_t                            last_noise;
    sample_t                            fs_count;
    sample_t                            dref_live;
    gain_t                              att_gain;
    logic                               cor_q;
    logic                               led_q;

    noise_squelch_controller DUT
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .noise_sample   (noise_sample),
        .diode_sample   (diode_sample),
        .knob_level     (knob_level),
        .calibrate      (calibrate),
        .store_diode    (store_diode),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .carrier_detect (carrier_detect),
        .led            (led),
        .gain_value     (gain_value),
        .gain_write     (gain_write),
        .cal_store      (cal_store),
        .diode_ref_out  (diode_ref_out),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // Free-running clock.
    always
    begin
        clk = 1'b0;
        #(HALF_PERIOD);
        clk = 1'b1;
        #(HALF_PERIOD);
    end

    // Saturate a signed band edge to the ADC range.
    function automatic int sat_adc(input int v);
        begin
            if (v < 0)
                return 0;
            if (v > int'(nsc_pkg::FULL_SCALE))
                return int'(nsc_pkg::FULL_SCALE);
            return v;
        end
    endfunction

    // Fast/slow counter step for a recent noise figure, as a lookup table.
    function automatic int noise_slope(input int figure);
        int upper[12] = '{16, 20, 24, 30, 36, 64, 72, 128, 144, 256, 512, 1024};
        int delta[12] = '{-15, -13, -11, -9, -7, -5, -3, -1, 1, 50, 100, 200};
        begin
            for (int i = 0; i < 12; i++)
            begin
                if (figure < upper[i])
                    return delta[i];
            end
            return delta[11];
        end
    endfunction

    function automatic void check_field(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
        begin
            if (got !== want)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            end
        end
    endfunction

    task automatic reset_model();
        begin
            reg_gain   = '0;
            reg_dref   = '0;
            sq_state   = SQ_CLOSED;
            cal_state  = CAL_START;
            hold_cnt   = '0;
            avg_noise  = nsc_pkg::CAL_NOISE;
            last_noise = '0;
            fs_count   = '0;
            dref_live  = '0;
            att_gain   = '0;
            cor_q      = 1'b0;
            led_q      = 1'b0;
        end
    endtask

    // One sample tick of the controller; returns the status beat it causes.
    task automatic squelch_tick_model(input tick_t t, output status_t r);
        int   knob;
        int   comp;
        int   band_lo;
        int   band_hi;
        int   recent;
        int   fs_sum;
        logic wr_pulse;
        logic st_pulse;
        begin
            wr_pulse = 1'b0;
            st_pulse = 1'b0;
            if (hold_cnt != '0)
                hold_cnt = hold_cnt - 1'b1;

            // Band around the knob, shifted by the diode drift.
            knob    = (t.knob < nsc_pkg::KNOB_MIN) ? int'(nsc_pkg::KNOB_MIN) : int'(t.knob);
            comp    = knob + int'(dref_live) - int'(t.diode);
            band_lo = sat_adc(comp - int'(nsc_pkg::HYST));
            band_hi = sat_adc(comp + int'(nsc_pkg::HYST));

            avg_noise = sample_t'((int'(avg_noise) * int'(nsc_pkg::AVG_TAPS)
                                   + int'(t.noise)) >> 5);

            recent     = (int'(t.noise) + int'(last_noise) + 1) >> 1;
            last_noise = t.noise;
            fs_sum     = int'(fs_count) + noise_slope(recent);
            if (fs_sum > int'(nsc_pkg::FS_LIMIT))
                fs_count = nsc_pkg::FS_LIMIT;
            else if (fs_sum < 0)
                fs_count = '0;
            else
                fs_count = sample_t'(fs_sum);

            if (t.cal)
            begin
                // Calibration always drops the carrier.
                cor_q = 1'b0;
                case (cal_state)
                    CAL_START:
                    begin
                        att_gain  = '0;
                        hold_cnt  = nsc_pkg::SETTLE_TICKS;
                        cal_state = CAL_DEBOUNCE;
                    end
                    CAL_DEBOUNCE:
                    begin
                        if (hold_cnt == '0)
                        begin
                            led_q     = 1'b0;
                            cal_state = CAL_SET;
                        end
                    end
                    CAL_SET:
                    begin
                        avg_noise = '0;
                        wr_pulse  = 1'b1;
                        led_q     = (att_gain[2:0] == 3'b111);
                        hold_cnt  = nsc_pkg::TEST_TICKS;
                        cal_state = CAL_TEST;
                    end
                    CAL_TEST:
                    begin
                        if (hold_cnt == '0)
                        begin
                            if (avg_noise > nsc_pkg::CAL_NOISE)
                            begin
                                if (att_gain < nsc_pkg::GAIN_MIN_OK)
                                    cal_state = CAL_TOO_HIGH;
                                else
                                begin
                                    if (t.store)
                                        dref_live = t.diode;
                                    st_pulse  = 1'b1;
                                    cal_state = CAL_DONE;
                                end
                            end
                            else
                            begin
                                att_gain  = att_gain + 1'b1;
                                cal_state = (att_gain > nsc_pkg::GAIN_TOP) ? CAL_TOO_LOW
                                                                           : CAL_SET;
                            end
                        end
                    end
                    CAL_DONE:
                        led_q = 1'b1;
                    CAL_TOO_LOW:
                    begin
                        if (hold_cnt == '0)
                        begin
                            led_q    = ~led_q;
                            hold_cnt = nsc_pkg::LOW_BLINK;
                        end
                    end
                    CAL_TOO_HIGH:
                    begin
                        if (hold_cnt == '0)
                        begin
                            led_q    = ~led_q;
                            hold_cnt = nsc_pkg::HIGH_BLINK;
                        end
                    end
                    default:
                        cal_state = CAL_START;
                endcase
            end
            else
            begin
                cal_state = CAL_START;
                case (sq_state)
                    SQ_CLOSED:
                    begin
                        led_q = 1'b0;
                        cor_q = 1'b0;
                        if (int'(avg_noise) < band_lo)
                        begin
                            fs_count = nsc_pkg::FS_LIMIT;
                            sq_state = SQ_OPEN;
                        end
                    end
                    SQ_OPEN:
                    begin
                        cor_q = 1'b1;
                        led_q = 1'b1;
                        if (fs_count == '0)
                            sq_state = SQ_OPEN_FAST;
                        else if (int'(avg_noise) >= band_hi)
                        begin
                            hold_cnt = nsc_pkg::CLOSE_TICKS;
                            sq_state = SQ_TAIL;
                        end
                    end
                    SQ_TAIL:
                    begin
                        cor_q = 1'b1;
                        led_q = 1'b1;
                        if (hold_cnt == '0)
                        begin
                            if (int'(avg_noise) < band_hi)
                            begin
                                fs_count = nsc_pkg::FS_LIMIT;
                                sq_state = SQ_OPEN;
                            end
                            else
                            begin
                                cor_q    = 1'b0;
                                led_q    = 1'b0;
                                sq_state = SQ_CLOSED;
                            end
                        end
                    end
                    SQ_OPEN_FAST:
                    begin
                        cor_q = 1'b1;
                        led_q = 1'b1;
                        if (fs_count > nsc_pkg::FS_THRESH)
                        begin
                            sq_state = SQ_OPEN;
                            fs_count = nsc_pkg::FS_LIMIT;
                        end
                        else if (int'(t.noise) >= band_hi)
                        begin
                            avg_noise = nsc_pkg::CAL_NOISE;
                            hold_cnt  = nsc_pkg::HOLDOFF_TICKS;
                            fs_count  = nsc_pkg::FS_LIMIT;
                            cor_q     = 1'b0;
                            led_q     = 1'b0;
                            sq_state  = SQ_HOLDOFF;
                        end
                    end
                    SQ_HOLDOFF:
                    begin
                        if (hold_cnt == '0)
                            sq_state = SQ_CLOSED;
                    end
                    default:
                        sq_state = SQ_CLOSED;
                endcase
            end

            r.cor     = cor_q;
            r.led     = led_q;
            r.gain    = att_gain;
            r.gain_wr = wr_pulse;
            r.store   = st_pulse;
            r.dref    = dref_live;
        end
    endtask

    // Output side: random stall bursts while enabled.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_stall_on && $urandom_range(0, 7) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(negedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // Compare every status beat with the oldest prediction.
    always @(posedge clk)
    begin : result_check
        status_t got;
        status_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{carrier_detect, led, gain_value, gain_write, cal_store, diode_ref_out};
            results_seen++;
            if (status_q.size() == 0)
            begin
                errors++;
                $display("%0t: status beat with none expected, expected nothing, got %p",
                         $time, got);
            end
            else
            begin
                want = status_q.pop_front();
                check_field("carrier_detect", 32'(want.cor), 32'(got.cor));
                check_field("led", 32'(want.led), 32'(got.led));
                check_field("gain_value", 32'(want.gain), 32'(got.gain));
                check_field("gain_write", 32'(want.gain_wr), 32'(got.gain_wr));
                check_field("cal_store", 32'(want.store), 32'(got.store));
                check_field("diode_ref_out", 32'(want.dref), 32'(got.dref));
            end
        end
    end

    // Send one sample beat; called and returning at a falling edge.
    task automatic send_tick(input sample_t noise, diode, knob,
                             input logic cal, store);
        tick_t   t;
        status_t want;
        begin
            if (tx_idle_on && $urandom_range(0, 7) == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 16)) @(negedge clk);
            end
            t = '{noise, diode, knob, cal, store};
            in_valid     <= 1'b1;
            noise_sample <= noise;
            diode_sample <= diode;
            knob_level   <= knob;
            calibrate    <= cal;
            store_diode  <= store;
            do
                @(posedge clk);
            while (!in_ready);
            squelch_tick_model(t, want);
            status_q.push_back(want);
            ticks_sent++;
            @(negedge clk);
        end
    endtask

    // Stop sending and let every expected beat come back.
    task automatic wait_results_done();
        begin
            in_valid <= 1'b0;
            while (status_q.size() != 0)
                @(negedge clk);
            repeat (4) @(negedge clk);
        end
    endtask

    task automatic apb_write(input addr_t addr, input word_t data);
        begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= addr;
            pwdata  <= data;
            @(negedge clk);
            penable <= 1'b1;
            do
                @(posedge clk);
            while (!pready);
            @(negedge clk);
            psel    <= 1'b0;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            // A register load also replaces the live value.
            if (addr == GAIN_ADDR)
            begin
                reg_gain = data[nsc_pkg::GAIN_W-1:0];
                att_gain = reg_gain;
            end
            else
            begin
                reg_dref  = data[nsc_pkg::SAMPLE_W-1:0];
                dref_live = reg_dref;
            end
            @(negedge clk);
        end
    endtask

    task automatic apb_read(input addr_t addr);
        word_t want;
        begin
            want = (addr == GAIN_ADDR) ? word_t'(reg_gain) : word_t'(reg_dref);
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            paddr   <= addr;
            @(negedge clk);
            penable <= 1'b1;
            do
                @(posedge clk);
            while (!pready);
            if (prdata !== want)
            begin
                errors++;
                $display("%0t: prdata mismatch at %0d, expected %0d, got %0d",
                         $time, addr, want, prdata);
            end
            @(negedge clk);
            psel    <= 1'b0;
            penable <= 1'b0;
            @(negedge clk);
        end
    endtask

    // Load a stored calibration while nothing is in flight, then read it back.
    task automatic load_stored_cal(input gain_t g, input sample_t d);
        begin
            wait_results_done();
            apb_write(GAIN_ADDR, word_t'(g));
            apb_write(DREF_ADDR, word_t'(d));
            apb_read(GAIN_ADDR);
            apb_read(DREF_ADDR);
        end
    endtask

    // Reset values read back, then writes with junk above the register width.
    task automatic test_register_access();
        word_t junk;
        begin
            apb_read(GAIN_ADDR);
            apb_read(DREF_ADDR);
            send_tick(10'd100, 10'd0, 10'd500, 1'b0, 1'b0);
            wait_results_done();
            junk = $urandom;
            apb_write(GAIN_ADDR, junk | word_t'(8'hFF));
            junk = $urandom;
            apb_write(DREF_ADDR, junk | word_t'(10'h3FF));
            apb_read(GAIN_ADDR);
            apb_read(DREF_ADDR);
        end
    endtask

    // Field extremes, band clamping, carrier drop and leaving calibration.
    task automatic test_field_extremes();
        begin
            // Knob under the minimum with a large drift pushes the band to the top.
            send_tick(10'd0, 10'd0, 10'd0, 1'b0, 1'b0);
            send_tick(10'd1023, 10'd1023, 10'd1023, 1'b0, 1'b1);
            send_tick(10'h2AA, 10'h155, 10'h2AA, 1'b0, 1'b1);
            send_tick(10'h155, 10'h2AA, 10'h155, 1'b0, 1'b0);
            send_tick(10'd0, 10'd0, 10'd25, 1'b0, 1'b0);
            send_tick(10'd0, 10'd0, 10'd26, 1'b0, 1'b0);
            load_stored_cal(8'd0, 10'd0);
            // Negative band edges clamp to zero, high ones to full scale.
            send_tick(10'd1023, 10'd1023, 10'd0, 1'b0, 1'b0);
            send_tick(10'd0, 10'd0, 10'd1023, 1'b0, 1'b1);
            send_tick(10'd0, 10'd0, 10'd1023, 1'b0, 1'b0);
            // Squelch open; calibration must drop the carrier.
            send_tick(10'd0, 10'd0, 10'd1023, 1'b1, 1'b0);
            send_tick(10'd1023, 10'd1023, 10'd1023, 1'b1, 1'b1);
            send_tick(10'd0, 10'd512, 10'd1023, 1'b1, 1'b1);
            send_tick(10'd0, 10'd0, 10'd1023, 1'b1, 1'b0);
            // Leaving calibration restarts it on the next calibration beat.
            send_tick(10'd0, 10'd0, 10'd1023, 1'b0, 1'b0);
            send_tick(10'd0, 10'd0, 10'd1023, 1'b1, 1'b0);
            send_tick(10'd1023, 10'd0, 10'd1023, 1'b0, 1'b1);
        end
    endtask

    // Segments of quiet, weak, loud, spiky and mixed noise and calibration bursts walk the squelch machine.
    task automatic test_squelch_traffic();
        segment_t mode;
        int       seg_len;
        int       knob;
        int       start_count;
        sample_t  noise;
        sample_t  diode;
        begin
            load_stored_cal(gain_t'($urandom_range(0, 255)),
                            sample_t'($urandom_range(100, 900)));
            start_count = ticks_sent;
            while (ticks_sent - start_count < 200)
            begin
                mode        = segment_t'($urandom_range(0, 5));
                knob        = ($urandom_range(0, 9) < 4) ? $urandom_range(0, 60)
                                                         : $urandom_range(0, 1023);
                tx_idle_on  = ($urandom_range(0, 3) != 0);
                rx_stall_on = ($urandom_range(0, 3) != 0);
                if (mode == SEG_SPIKE)
                    seg_len = $urandom_range(1, 3);
                else if (mode == SEG_CAL_BURST)
                    seg_len = $urandom_range(1, 6);
                else
                    seg_len = $urandom_range(5, 60);
                repeat (seg_len)
                begin
                    case (mode)
                        SEG_QUIET: noise = sample_t'($urandom_range(0, 15));
                        SEG_WEAK:  noise = sample_t'($urandom_range(16, 150));
                        SEG_LOUD:  noise = sample_t'($urandom_range(500, 1023));
                        SEG_SPIKE: noise = sample_t'(sat_adc((knob < 26 ? 26 : knob)
                                                    + int'(nsc_pkg::HYST)
                                                    + int'($urandom_range(0, 4))));
                        default:   noise = sample_t'($urandom_range(0, 1023));
                    endcase
                    // Mostly a small drift around the stored diode reference.
                    if (mode == SEG_SPIKE)
                        diode = dref_live;
                    else if ($urandom_range(0, 19) < 17)
                        diode = sample_t'(sat_adc(int'(dref_live)
                                                  + int'($urandom_range(0, 16)) - 8));
                    else
                        diode = sample_t'($urandom_range(0, 1023));
                    send_tick(noise, diode, sample_t'(knob), mode == SEG_CAL_BURST,
                              1'($urandom_range(0, 1)));
                end
            end
            tx_idle_on  = 1'b1;
            rx_stall_on = 1'b1;
        end
    endtask

    // Low noise until the gain has stepped past the minimum, then loud noise.
    task automatic test_calibration_pass();
        int guard;
        begin
            load_stored_cal(gain_t'($urandom_range(0, 255)),
                            sample_t'($urandom_range(0, 1023)));
            guard = 0;
            while (cal_state != CAL_DONE && guard < 3000)
            begin
                send_tick((att_gain < nsc_pkg::GAIN_MIN_OK)
                              ? sample_t'($urandom_range(0, 400))
                              : sample_t'($urandom_range(990, 1023)),
                          sample_t'($urandom), sample_t'($urandom), 1'b1,
                          1'($urandom_range(0, 1)));
                guard++;
            end
            repeat (12)
                send_tick(sample_t'($urandom), sample_t'($urandom), sample_t'($urandom),
                          1'b1, 1'($urandom_range(0, 1)));
            repeat (4)
                send_tick(sample_t'($urandom), sample_t'($urandom), sample_t'($urandom),
                          1'b0, 1'($urandom_range(0, 1)));
        end
    endtask

    // Loud noise at a low gain ends in the blinking error state.
    task automatic test_calibration_fault();
        int guard;
        begin
            load_stored_cal(gain_t'($urandom_range(0, 255)),
                            sample_t'($urandom_range(0, 1023)));
            guard = 0;
            while (cal_state != CAL_TOO_HIGH && guard < 600)
            begin
                send_tick(sample_t'($urandom_range(990, 1023)), sample_t'($urandom),
                          sample_t'($urandom), 1'b1, 1'($urandom_range(0, 1)));
                guard++;
            end
            repeat (40)
                send_tick(sample_t'($urandom), sample_t'($urandom), sample_t'($urandom),
                          1'b1, 1'($urandom_range(0, 1)));
            repeat (4)
                send_tick(sample_t'($urandom), sample_t'($urandom), sample_t'($urandom),
                          1'b0, 1'($urandom_range(0, 1)));
        end
    endtask

    // Unshaped beats; the closing stretch runs without gaps or stalls.
    task automatic test_random_ticks();
        begin
            load_stored_cal(gain_t'($urandom_range(0, 255)),
                            sample_t'($urandom_range(0, 1023)));
            repeat (60)
                send_tick(sample_t'($urandom), sample_t'($urandom), sample_t'($urandom),
                          $urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)));
            tx_idle_on  = 1'b0;
            rx_stall_on = 1'b0;
            repeat (40)
                send_tick(sample_t'($urandom), sample_t'($urandom), sample_t'($urandom),
                          $urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)));
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        noise_sample = '0;
        diode_sample = '0;
        knob_level   = '0;
        calibrate    = 1'b0;
        store_diode  = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        reset_model();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_register_access();
        test_field_extremes();
        test_squelch_traffic();
        test_calibration_pass();
        test_calibration_fault();
        test_random_ticks();

        wait_results_done();
        repeat (10) @(negedge clk);
        $display("Sent %0d ticks and checked %0d status beats over squelch traffic,", ticks_sent,
                 results_seen);
        $display("calibration success and fault, and register loads at both extremes.");
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #5_000_000;
        $display("%0t: run did not finish in time", $time);
        $display("*** FAILED ***");
        $finish;
    end

endmodule

### files.f
rtl/core/nsc_pkg.sv
rtl/core/nsc_cond.sv
rtl/core/nsc_ctrl.sv
rtl/core/noise_squelch_controller.sv
bench/tb_noise_squelch_controller.sv
